// ===== sv/mrlp_pkg.sv =====
// Package for the modem response line parser: sizes, codes, status word table,
// and the command and status structs between controller and datapath.
// No dependencies.
package mrlp_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int STORE_BYTES = 32;
    localparam int LINE_W      = $clog2(LINE_BYTES);
    localparam int COUNT_W     = $clog2(STORE_BYTES + 1);
    localparam int NUM_WORDS   = 16;
    localparam int PREFIX_LEN  = 7;

    localparam logic [4:0] CODE_RX     = 5'd10;
    localparam logic [4:0] CODE_BANNER = 5'd15;
    localparam logic [4:0] CODE_NONE   = 5'd16;
    localparam logic [3:0] IDX_RX      = 4'd10;
    localparam logic [3:0] IDX_BANNER  = 4'd15;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // Controller to datapath
    typedef struct packed {
        logic idle;   // input side open
        logic rd;     // read store at scan index
        logic step;   // consume the byte read
        logic fin;    // load the status result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic start;     // line ended, scan needed
        logic emit;      // current byte completes a data result
        logic stop;      // that data result is the last one
        logic endk;      // current byte is the last of the text
        logic sent;      // a data result went out on this line
        logic out_free;  // output register can take a result
    } t_sts;

    // Status words as ASCII bytes, text right-aligned
    function automatic logic [255:0] word_text(input logic [3:0] idx);
        logic [255:0] t;
        case (idx)
            4'd0:    t = 256'("ok");
            4'd1:    t = 256'({8'h69, 8'h6E, 8'h76, 8'h61, 8'h6C, 8'h69, 8'h64, 8'h5F,
                               8'h70, 8'h61, 8'h72, 8'h61, 8'h6D});
            4'd2:    t = 256'({8'h6E, 8'h6F, 8'h74, 8'h5F, 8'h6A, 8'h6F, 8'h69, 8'h6E,
                               8'h65, 8'h64});
            4'd3:    t = 256'({8'h6E, 8'h6F, 8'h5F, 8'h66, 8'h72, 8'h65, 8'h65, 8'h5F,
                               8'h63, 8'h68});
            4'd4:    t = 256'("silent");
            4'd5:    t = 256'({8'h66, 8'h72, 8'h61, 8'h6D, 8'h65, 8'h5F, 8'h63, 8'h6F,
                               8'h75, 8'h6E, 8'h74, 8'h65, 8'h72, 8'h5F, 8'h65, 8'h72,
                               8'h72, 8'h5F, 8'h72, 8'h65, 8'h6A, 8'h6F, 8'h69, 8'h6E,
                               8'h5F, 8'h6E, 8'h65, 8'h65, 8'h64, 8'h65, 8'h64});
            4'd6:    t = 256'("busy");
            4'd7:    t = 256'({8'h6D, 8'h61, 8'h63, 8'h5F, 8'h70, 8'h61, 8'h75, 8'h73,
                               8'h65, 8'h64});
            4'd8:    t = 256'({8'h69, 8'h6E, 8'h76, 8'h61, 8'h6C, 8'h69, 8'h64, 8'h5F,
                               8'h64, 8'h61, 8'h74, 8'h61, 8'h5F, 8'h6C, 8'h65, 8'h6E});
            4'd9:    t = 256'({8'h6D, 8'h61, 8'h63, 8'h5F, 8'h74, 8'h78, 8'h5F, 8'h6F,
                               8'h6B});
            4'd10:   t = 256'("mac_rx ");
            4'd11:   t = 256'("mac_err");
            4'd12:   t = 256'({8'h6B, 8'h65, 8'h79, 8'h73, 8'h5F, 8'h6E, 8'h6F, 8'h74,
                               8'h5F, 8'h69, 8'h6E, 8'h69, 8'h74});
            4'd13:   t = 256'("denied");
            4'd14:   t = 256'("accepted");
            default: t = 256'({8'h52, 8'h4E, 8'h32, 8'h39, 8'h30, 8'h33, 8'h20}); // banner
        endcase
        return t;
    endfunction

    function automatic logic [4:0] word_len(input logic [3:0] idx);
        logic [4:0] n;
        case (idx)
            4'd0:    n = 5'd2;
            4'd1:    n = 5'd13;
            4'd2:    n = 5'd10;
            4'd3:    n = 5'd10;
            4'd4:    n = 5'd6;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd4;
            4'd7:    n = 5'd10;
            4'd8:    n = 5'd16;
            4'd9:    n = 5'd9;
            4'd10:   n = 5'd7;
            4'd11:   n = 5'd7;
            4'd12:   n = 5'd13;
            4'd13:   n = 5'd6;
            4'd14:   n = 5'd8;
            default: n = 5'd7;
        endcase
        return n;
    endfunction

    // Character pos of word idx; valid for pos below the word length
    function automatic logic [7:0] word_char(input logic [3:0] idx, input logic [4:0] pos);
        logic [255:0] t;
        logic [4:0]   p;
        t = word_text(idx);
        p = word_len(idx) - 5'd1 - pos;
        return t[{p, 3'b000} +: 8];
    endfunction

endpackage

// ===== sv/mrlp_ctrl.sv =====
// Controller of the modem response line parser: sequences the scan of a
// finished line over the line store. Depends on mrlp_pkg.
module mrlp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mrlp_pkg::t_sts i_sts,
    output mrlp_pkg::t_cmd o_cmd
);
    import mrlp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_EVAL, S_FIN} t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.start) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (!i_sts.emit || i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.stop) begin
                        n_state = S_IDLE;
                    end else if (i_sts.endk) begin
                        n_state = i_sts.sent ? S_IDLE : S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/mrlp_dp.sv =====
// Datapath of the modem response line parser: line store, word matching,
// port and hex decoding, output register. Depends on mrlp_pkg.
module mrlp_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrlp_pkg::t_cmd i_cmd,
    output mrlp_pkg::t_sts o_sts,
    input  logic           i_valid,
    input  logic           i_mode,
    input  logic [7:0]     i_rx_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [4:0]     o_status_code,
    output logic [7:0]     o_rx_port,
    output logic [7:0]     o_data_byte,
    output logic           o_last
);
    import mrlp_pkg::*;

    typedef enum logic [1:0] {PH_PFX, PH_PORT, PH_HI, PH_LO} t_phase;

    logic [7:0]           r_mem [LINE_BYTES];
    logic [7:0]           r_rdata;
    logic [LINE_W-1:0]    r_len;
    logic [COUNT_W-1:0]   r_count;
    logic [LINE_W-1:0]    r_k;
    logic [LINE_W-1:0]    r_tlen;
    logic [NUM_WORDS-1:0] r_match, n_match;
    t_phase               r_ph, n_ph;
    logic [7:0]           r_port, n_port;
    logic [3:0]           r_hi;
    logic                 r_sent;
    logic                 r_ovalid;
    logic                 r_kind;
    logic [4:0]           r_code;
    logic [7:0]           r_oport;
    logic [7:0]           r_odata;
    logic                 r_last;

    logic                 acc, lf_line;
    logic [LINE_W:0]      new_len;
    logic [3:0]           nib;
    logic                 is_digit, endk, emit, stop;
    logic [7:0]           data_val;
    logic [4:0]           st_code;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    // Input side
    assign acc     = i_valid && i_cmd.idle;
    assign new_len = {1'b0, r_len} + 1'b1;
    assign lf_line = acc && !i_mode && (i_rx_byte == CH_LF) && (new_len > 2);

    // Per-byte decode
    assign nib      = hex_val(r_rdata);
    assign is_digit = (r_rdata >= CH_ZERO) && (r_rdata <= CH_NINE);
    assign endk     = (r_k == r_tlen - 1'b1);
    assign emit     = r_match[IDX_RX] && (r_count < COUNT_W'(STORE_BYTES))
                      && ((r_ph == PH_HI && endk) || r_ph == PH_LO);
    assign stop     = emit && (endk || r_count == COUNT_W'(STORE_BYTES - 1));
    assign data_val = (r_ph == PH_LO) ? {r_hi, nib} : {nib, 4'h0};

    // Word match and mac_rx parse update
    always_comb begin
        n_match = r_match;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (r_k < LINE_W'(word_len(4'(i)))
                    && r_rdata != word_char(4'(i), r_k[4:0]))
                n_match[i] = 1'b0;
        end
        n_ph   = r_ph;
        n_port = r_port;
        case (r_ph)
            PH_PFX:  if (r_k == LINE_W'(PREFIX_LEN - 1)) n_ph = PH_PORT;
            PH_PORT: begin
                if (is_digit) n_port = r_port * 8'd10 + {4'h0, r_rdata[3:0]};
                else n_ph = PH_HI;     // one char after the digits is skipped
            end
            PH_HI:   n_ph = PH_LO;
            PH_LO:   n_ph = PH_HI;
            default: n_ph = PH_PFX;
        endcase
    end

    // Status code at end of line
    always_comb begin
        st_code = CODE_NONE;
        if (r_match[IDX_BANNER] && r_tlen >= LINE_W'(PREFIX_LEN)) st_code = CODE_BANNER;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (r_match[i] && r_tlen == LINE_W'(word_len(4'(i)))) st_code = 5'(i);
        end
    end

    // Line store
    always_ff @(posedge i_clk) begin
        if (acc && !i_mode) r_mem[r_len] <= i_rx_byte;
        if (i_cmd.rd) r_rdata <= r_mem[r_k];
    end

    // Line length and stored count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
        end else begin
            if (acc) begin
                if (i_mode || i_rx_byte == CH_LF || new_len == (LINE_W + 1)'(LINE_BYTES))
                    r_len <= '0;
                else
                    r_len <= new_len[LINE_W-1:0];
            end
            if (acc && i_mode) r_count <= '0;
            else if (i_cmd.step && emit) r_count <= r_count + 1'b1;
        end
    end

    // Scan registers
    always_ff @(posedge i_clk) begin
        if (lf_line) begin
            r_tlen  <= LINE_W'(new_len - 2'd2);
            r_k     <= '0;
            r_match <= '1;
            r_ph    <= PH_PFX;
            r_port  <= '0;
            r_sent  <= 1'b0;
        end else if (i_cmd.step) begin
            r_k     <= r_k + 1'b1;
            r_match <= n_match;
            r_ph    <= n_ph;
            r_port  <= n_port;
            if (r_ph == PH_HI) r_hi <= nib;
            if (emit) r_sent <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((i_cmd.step && emit) || i_cmd.fin) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.step && emit) begin
            r_kind  <= 1'b1;
            r_code  <= CODE_RX;
            r_oport <= r_port;
            r_odata <= data_val;
            r_last  <= stop;
        end else if (i_cmd.fin) begin
            r_kind  <= 1'b0;
            r_code  <= st_code;
            r_oport <= '0;
            r_odata <= '0;
            r_last  <= 1'b1;
        end
    end

    assign o_sts.start    = lf_line;
    assign o_sts.emit     = emit;
    assign o_sts.stop     = stop;
    assign o_sts.endk     = endk;
    assign o_sts.sent     = r_sent;
    assign o_sts.out_free = !r_ovalid || i_ready;

    assign o_valid       = r_ovalid;
    assign o_kind        = r_kind;
    assign o_status_code = r_code;
    assign o_rx_port     = r_oport;
    assign o_data_byte   = r_odata;
    assign o_last        = r_last;

endmodule

// ===== sv/modem_response_line_parser.sv =====
// Top level of the modem response line parser: controller plus datapath.
// Depends on mrlp_pkg, mrlp_ctrl, mrlp_dp.
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_ready   i_mode, i_rx_byte
//   result   out        o_valid / i_ready   o_kind, o_status_code, o_rx_port,
//                                           o_data_byte, o_last
//
// An ordinary byte or a clear request is taken only while the controller is idle.
// A closing LF starts a scan of the line store: each text byte is read from the
// store (S_RD), then decoded (S_EVAL); if no data result went out, a status
// result is loaded in S_FIN. New bytes are not taken until the scan ends.
// Results leave through an output register; a stalled result holds the scan.
// Synchronous active-low reset empties the line and the stored count.
module modem_response_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [4:0] o_status_code,
    output logic [7:0] o_rx_port,
    output logic [7:0] o_data_byte,
    output logic       o_last
);
    import mrlp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mrlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mrlp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_status_code (o_status_code),
        .o_rx_port     (o_rx_port),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last)
    );

    assign o_ready = cmd.idle;

endmodule

// ===== tb/sv/mrlp_tb_pkg.sv =====
`timescale 1ns / 100ps
// Shared codes, status word table and the result record for the parser
// testbench. No dependencies.
package mrlp_tb_pkg;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic       kind;
        logic [4:0] code;
        logic [7:0] port;
        logic [7:0] data;
        logic       last;
    } t_line_result;

    // Status words as ASCII bytes, text right-aligned
    function automatic logic [255:0] status_text(input int idx);
        logic [255:0] t;
        case (idx)
            0:       t = 256'("ok");
            1:       t = 256'({8'h69, 8'h6E, 8'h76, 8'h61, 8'h6C, 8'h69, 8'h64, 8'h5F,
                               8'h70, 8'h61, 8'h72, 8'h61, 8'h6D});
            2:       t = 256'({8'h6E, 8'h6F, 8'h74, 8'h5F, 8'h6A, 8'h6F, 8'h69, 8'h6E,
                               8'h65, 8'h64});
            3:       t = 256'({8'h6E, 8'h6F, 8'h5F, 8'h66, 8'h72, 8'h65, 8'h65, 8'h5F,
                               8'h63, 8'h68});
            4:       t = 256'("silent");
            5:       t = 256'({8'h66, 8'h72, 8'h61, 8'h6D, 8'h65, 8'h5F, 8'h63, 8'h6F,
                               8'h75, 8'h6E, 8'h74, 8'h65, 8'h72, 8'h5F, 8'h65, 8'h72,
                               8'h72, 8'h5F, 8'h72, 8'h65, 8'h6A, 8'h6F, 8'h69, 8'h6E,
                               8'h5F, 8'h6E, 8'h65, 8'h65, 8'h64, 8'h65, 8'h64});
            6:       t = 256'("busy");
            7:       t = 256'({8'h6D, 8'h61, 8'h63, 8'h5F, 8'h70, 8'h61, 8'h75, 8'h73,
                               8'h65, 8'h64});
            8:       t = 256'({8'h69, 8'h6E, 8'h76, 8'h61, 8'h6C, 8'h69, 8'h64, 8'h5F,
                               8'h64, 8'h61, 8'h74, 8'h61, 8'h5F, 8'h6C, 8'h65, 8'h6E});
            9:       t = 256'({8'h6D, 8'h61, 8'h63, 8'h5F, 8'h74, 8'h78, 8'h5F, 8'h6F,
                               8'h6B});
            10:      t = 256'("mac_rx ");
            11:      t = 256'("mac_err");
            12:      t = 256'({8'h6B, 8'h65, 8'h79, 8'h73, 8'h5F, 8'h6E, 8'h6F, 8'h74,
                               8'h5F, 8'h69, 8'h6E, 8'h69, 8'h74});
            13:      t = 256'("denied");
            14:      t = 256'("accepted");
            default: t = 256'({8'h52, 8'h4E, 8'h32, 8'h39, 8'h30, 8'h33, 8'h20}); // banner
        endcase
        return t;
    endfunction

    function automatic int status_len(input int idx);
        int n;
        case (idx)
            0:       n = 2;
            1:       n = 13;
            2:       n = 10;
            3:       n = 10;
            4:       n = 6;
            5:       n = 31;
            6:       n = 4;
            7:       n = 10;
            8:       n = 16;
            9:       n = 9;
            10:      n = 7;
            11:      n = 7;
            12:      n = 13;
            13:      n = 6;
            14:      n = 8;
            default: n = 7;
        endcase
        return n;
    endfunction

    // Byte k of status word idx, first character at k = 0
    function automatic logic [7:0] status_byte(input int idx, input int k);
        logic [255:0] t;
        t = status_text(idx);
        return t[(status_len(idx) - 1 - k) * 8 +: 8];
    endfunction

endpackage

// ===== tb/sv/modem_response_line_parser_check.sv =====
`timescale 1ns / 100ps
// Checker for the modem response line parser: follows accepted requests,
// predicts the line results and compares every accepted result with them.
// Depends on mrlp_pkg and mrlp_tb_pkg.
module modem_response_line_parser_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic       o_kind,
    input  logic [4:0] o_status_code,
    input  logic [7:0] o_rx_port,
    input  logic [7:0] o_data_byte,
    input  logic       o_last,
    output int         o_fail_count,
    output int         o_pending
);
    import mrlp_pkg::*;
    import mrlp_tb_pkg::*;

    localparam int MAX_PER_LINE = 32;

    logic [7:0]   line_buf [LINE_BYTES];
    int           line_len;
    int           delivered;
    t_line_result expected_q [$];

    function automatic bit text_matches(input int tlen, input int idx, input bit exact);
        int wl;
        wl = status_len(idx);
        if (exact ? (tlen != wl) : (tlen < wl))
            return 0;
        for (int k = 0; k < wl; k++)
            if (line_buf[k] != status_byte(idx, k))
                return 0;
        return 1;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    // Classify a finished line of tlen text bytes into expected results
    task automatic classify_line(input int tlen);
        t_line_result r, got [$];
        int           i;
        logic [7:0]   port;
        logic [3:0]   hi, lo;
        r = '0;
        for (int w = 0; w < 16 && got.size() == 0; w++)
            if (text_matches(tlen, w, 1)) begin
                r.code = 5'(w);
                got.push_back(r);
            end
        if (got.size() == 0 && text_matches(tlen, IDX_BANNER, 0)) begin
            r.code = CODE_BANNER;
            got.push_back(r);
        end
        if (got.size() == 0 && text_matches(tlen, IDX_RX, 0)) begin
            i = PREFIX_LEN;
            port = 0;
            while (i < tlen && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
                port = port * 8'd10 + (line_buf[i] - CH_ZERO);
                i++;
            end
            i++;  // one separator after the digits
            for (; i < tlen; i += 2) begin
                if (delivered >= STORE_BYTES || got.size() >= MAX_PER_LINE)
                    break;
                hi = nibble_of(line_buf[i]);
                lo = (i + 1 < tlen) ? nibble_of(line_buf[i + 1]) : 4'd0;
                r.kind = KIND_DATA;
                r.code = CODE_RX;
                r.port = port;
                r.data = {hi, lo};
                got.push_back(r);
                delivered++;
            end
        end
        if (got.size() == 0) begin
            r = '0;
            r.code = CODE_NONE;
            got.push_back(r);
        end
        got[got.size() - 1].last = 1'b1;
        foreach (got[k])
            expected_q.push_back(got[k]);
    endtask

    task automatic take_request(input logic mode, input logic [7:0] b);
        if (mode == MODE_CLEAR) begin
            line_len = 0;
            delivered = 0;
            return;
        end
        if (line_len >= LINE_BYTES)
            line_len = 0;
        line_buf[line_len] = b;
        line_len++;
        if (b == CH_LF && line_len > 2)
            classify_line(line_len - 2);
        if (line_len >= LINE_BYTES || b == CH_LF)
            line_len = 0;
    endtask

    task automatic report(input string field, input int want, input int seen);
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, seen);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        line_len = 0;
        delivered = 0;
    end

    // Compare results, then predict from the request taken at this edge
    always @(posedge i_clk) begin
        t_line_result w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual kind %0h code %0h",
                             $time, o_kind, o_status_code);
                    o_fail_count++;
                end else begin
                    w = expected_q.pop_front();
                    if (o_kind != w.kind)        report("kind", w.kind, o_kind);
                    if (o_status_code != w.code) report("status_code", w.code, o_status_code);
                    if (o_rx_port != w.port)     report("rx_port", w.port, o_rx_port);
                    if (o_data_byte != w.data)   report("data_byte", w.data, o_data_byte);
                    if (o_last != w.last)        report("last", w.last, o_last);
                end
            end
            if (i_valid && o_ready)
                take_request(i_mode, i_rx_byte);
        end
        o_pending <= expected_q.size();
    end

endmodule

// ===== tb/sv/modem_response_line_parser_test.sv =====
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, request stimulus, result stalls
// and verdict. Depends on mrlp_pkg, mrlp_tb_pkg, the checker and the block.
module modem_response_line_parser_test;
    import mrlp_pkg::*;
    import mrlp_tb_pkg::*;

    localparam int TOTAL_REQS = 220;
    localparam int IDLE_LIMIT = 5000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_mode;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_kind;
    logic [4:0] o_status_code;
    logic [7:0] o_rx_port;
    logic [7:0] o_data_byte;
    logic       o_last;
    int         fail_count;
    int         pending;

    int         burst_left;
    int         reqs_sent;
    int         hold_left;
    int         ready_style;
    int         idle_cycles;

    modem_response_line_parser dut (.*);

    modem_response_line_parser_check checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_rx_byte, .o_valid, .i_ready,
        .o_kind, .o_status_code, .o_rx_port, .o_data_byte, .o_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Send one request; the sender idles between bursts
    task automatic put_request(input logic mode, input logic [7:0] b);
        i_valid <= 1'b1;
        i_mode <= mode;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        reqs_sent++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_line(input logic [7:0] q [$]);
        foreach (q[k])
            put_request(MODE_BYTE, q[k]);
        put_request(MODE_BYTE, CH_CR);
        put_request(MODE_BYTE, CH_LF);
    endtask

    function automatic void add_text(ref logic [7:0] q [$], input string s);
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
    endfunction

    function automatic void add_word(ref logic [7:0] q [$], input int w);
        for (int k = 0; k < status_len(w); k++)
            q.push_back(status_byte(w, k));
    endfunction

    function automatic logic [7:0] any_hex_char();
        string hex_set;
        hex_set = "0123456789ABCDEFabcdefgZ: ";
        return hex_set[$urandom_range(0, hex_set.len() - 1)];
    endfunction

    // mac_rx line with port digits, at most one separator and hex payload
    function automatic void add_rx_line(ref logic [7:0] q [$], input int digits,
                                        input int hex_chars);
        add_text(q, "mac_rx ");
        repeat (digits) q.push_back(8'("0" + $urandom_range(0, 9)));
        if (digits > 0 || $urandom_range(0, 1))
            q.push_back($urandom_range(0, 3) == 0 ? 8'h2C : 8'h20);
        repeat (hex_chars) q.push_back(any_hex_char());
    endfunction

    function automatic void add_noise(ref logic [7:0] q [$], input int n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(0, 255));
            q.push_back(c == CH_LF ? 8'h00 : c);
        end
    endfunction

    // Result side stalls on its own pattern; a requested hold-off wins
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            case (ready_style)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
            if ($urandom_range(0, 40) == 0)
                ready_style = $urandom_range(0, 2);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [7:0] q [$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_BYTE;
        i_rx_byte = 8'h00;
        i_ready = 1'b0;
        burst_left = 0;
        reqs_sent = 0;
        hold_left = 0;
        ready_style = 0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short lines
        put_request(MODE_BYTE, CH_LF);
        put_request(MODE_BYTE, CH_CR);
        put_request(MODE_BYTE, CH_LF);
        // LF as the last byte of a full line, while the result side holds off
        hold_left = 400;
        q = {}; add_text(q, "mac_rx 1 "); repeat (53) q.push_back(any_hex_char());
        send_line(q);
        // Fill the stored count up to its cap, then a line past it
        q = {}; add_text(q, "mac_rx 300 00ffA5c"); send_line(q);
        q = {}; add_text(q, "mac_rx 9 abcdef"); send_line(q);
        q = {}; add_text(q, "mac_rx 7 zz9g"); send_line(q);
        put_request(MODE_CLEAR, 8'hFF);

        // Pause until every expected result has come
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);

        // Random lines, mostly well formed with random content
        while (reqs_sent < TOTAL_REQS) begin
            q = {};
            case ($urandom_range(0, 9))
                0, 1: begin
                    int w;
                    w = $urandom_range(0, 15);
                    add_word(q, w);
                    if ($urandom_range(0, 3) == 0) add_noise(q, 1);
                    send_line(q);
                end
                2: begin
                    add_word(q, IDX_BANNER);
                    add_noise(q, $urandom_range(0, 8));
                    send_line(q);
                end
                3, 4, 5: begin
                    if ($urandom_range(0, 1))
                        put_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
                    add_rx_line(q, $urandom_range(0, 4), $urandom_range(0, 12));
                    send_line(q);
                end
                6: begin
                    add_noise(q, $urandom_range(0, 12));
                    send_line(q);
                end
                7: begin
                    add_noise(q, $urandom_range(64, 72));
                    send_line(q);
                end
                8: put_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
                default: begin
                    put_request(MODE_BYTE, 8'($urandom_range(0, 255)));
                    put_request(MODE_BYTE, CH_LF);
                end
            endcase
        end
        i_valid <= 1'b0;

        // Drain, then let the scan settle
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mrlp_pkg.sv
sv/mrlp_ctrl.sv
sv/mrlp_dp.sv
sv/modem_response_line_parser.sv
tb/sv/mrlp_tb_pkg.sv
tb/sv/modem_response_line_parser_check.sv
tb/sv/modem_response_line_parser_test.sv
